FILE: hdl/vpsw_pkg.sv
package vpsw_pkg;

  localparam int POS_W      = 24;  // Q3.20 position
  localparam int ACC_W      = 32;  // Q11.20 acceleration
  localparam int DRAG_W     = 24;  // Q8.16 drag
  localparam int STEP_W     = 32;  // Q0.32 squared step
  localparam int BOUND_W    = 23;  // Q3.20 wall bound, unsigned
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [STEP_W-1:0]  STEP_SQUARED_RST = 32'd1193046;
  localparam logic [BOUND_W-1:0] WALL_BOUND_RST   = 23'd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SQUARED = 2'd0,
    CFG_WALL_BOUND_X = 2'd1,
    CFG_WALL_BOUND_Y = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_y;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic [DRAG_W-1:0]       drag;
  } particle_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_pos_x;
    logic signed [POS_W-1:0] new_pos_y;
    logic signed [POS_W-1:0] new_prev_x;
    logic signed [POS_W-1:0] new_prev_y;
    logic                    hit_wall_x;
    logic                    hit_wall_y;
  } result_t;

endpackage

FILE: hdl/vpsw_chan_if.sv
interface vpsw_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/verlet_particle_step_with_walls.sv
// Position-Verlet step of one 2D particle with wall bounce (restitution 1/2).
// A transaction on particle carries pos, prev, accel and drag; each one gives
// exactly one transaction on result, in order, after stages 1 to 6. One
// transaction is taken every cycle while result is not stalled: the pipeline
// has six register stages, with the two multipliers per axis (25x25 drag
// product, 32x33 step product) each in a stage of their own. Valid bits
// travel with the data; a stalled result holds its stage, and empty stages
// upstream still fill, so bubbles are squeezed out. Config registers
// (step_squared, wall bounds) are read live by the pipeline and must only
// be written while no transaction is in flight.
//
// Per axis:
//   disp  = pos - prev
//   force = sat32(accel - floor(disp * drag / 2^16))
//   p     = sat24(pos + disp + floor(force * step_squared / 2^32))
//   |p| > bound -> new_pos = +-bound, new_prev = sat24(wall + floor((p-pos)/2))
//   otherwise   -> new_pos = p, new_prev = pos
module verlet_particle_step_with_walls (
  input  logic                               clk,
  input  logic                               rst,
  vpsw_chan_if.sink                          particle,
  vpsw_chan_if.source                        result,
  input  logic                               cfg_we,
  input  logic [vpsw_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [vpsw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vpsw_pkg::*;

  localparam int NSTG = 6;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]  step_squared;
  logic [BOUND_W-1:0] wall_bound [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_squared  <= STEP_SQUARED_RST;
      wall_bound[0] <= WALL_BOUND_RST;
      wall_bound[1] <= WALL_BOUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_STEP_SQUARED: step_squared  <= cfg_data[STEP_W-1:0];
        CFG_WALL_BOUND_X: wall_bound[0] <= cfg_data[BOUND_W-1:0];
        CFG_WALL_BOUND_Y: wall_bound[1] <= cfg_data[BOUND_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids and enables. A stage loads when it is empty or the stage
  // after it moves on.
  // ---------------------------------------------------------------------------
  logic [NSTG:1] vld;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld[NSTG] || result.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign particle.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= particle.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpack, axis 0 = x, axis 1 = y
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0] in_pos  [2];
  logic signed [POS_W-1:0] in_prev [2];
  logic signed [ACC_W-1:0] in_acc  [2];

  assign in_pos[0]  = particle.data.pos_x;
  assign in_pos[1]  = particle.data.pos_y;
  assign in_prev[0] = particle.data.prev_x;
  assign in_prev[1] = particle.data.prev_y;
  assign in_acc[0]  = particle.data.accel_x;
  assign in_acc[1]  = particle.data.accel_y;

  // ---------------------------------------------------------------------------
  // Stage 1: displacement
  // ---------------------------------------------------------------------------
  logic signed [POS_W:0]   s1_disp [2];
  logic signed [POS_W-1:0] s1_pos  [2];
  logic signed [ACC_W-1:0] s1_acc  [2];
  logic [DRAG_W-1:0]       s1_drag;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 2; a++) begin
        s1_disp[a] <= {in_pos[a][POS_W-1], in_pos[a]} - {in_prev[a][POS_W-1], in_prev[a]};
        s1_pos[a]  <= in_pos[a];
        s1_acc[a]  <= in_acc[a];
      end
      s1_drag <= particle.data.drag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: drag product, floor(disp * drag / 2^16)
  // ---------------------------------------------------------------------------
  localparam int DPROD_W = POS_W + 1 + DRAG_W + 1;  // 50
  localparam int DTERM_W = DPROD_W - 16;            // 34

  logic signed [DRAG_W:0]    drag_s;
  logic signed [DPROD_W-1:0] drag_prod [2];
  logic signed [DTERM_W-1:0] s2_dterm  [2];
  logic signed [POS_W:0]     s2_disp   [2];
  logic signed [POS_W-1:0]   s2_pos    [2];
  logic signed [ACC_W-1:0]   s2_acc    [2];

  assign drag_s = $signed({1'b0, s1_drag});

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      drag_prod[a] = DPROD_W'(s1_disp[a]) * DPROD_W'(drag_s);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 2; a++) begin
        s2_dterm[a] <= drag_prod[a][DPROD_W-1:16];
        s2_disp[a]  <= s1_disp[a];
        s2_pos[a]   <= s1_pos[a];
        s2_acc[a]   <= s1_acc[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: force = sat32(accel - dragterm)
  // ---------------------------------------------------------------------------
  localparam int FDIFF_W = DTERM_W + 1;  // 35

  logic signed [FDIFF_W-1:0] fdiff   [2];
  logic signed [ACC_W-1:0]   s3_force [2];
  logic signed [POS_W:0]     s3_disp  [2];
  logic signed [POS_W-1:0]   s3_pos   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fdiff[a] = FDIFF_W'(s2_acc[a]) - FDIFF_W'(s2_dterm[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < 2; a++) begin
        if ((&fdiff[a][FDIFF_W-1:ACC_W-1]) || !(|fdiff[a][FDIFF_W-1:ACC_W-1])) begin
          s3_force[a] <= fdiff[a][ACC_W-1:0];
        end else begin
          s3_force[a] <= fdiff[a][FDIFF_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : {1'b0, {(ACC_W-1){1'b1}}};
        end
        s3_disp[a] <= s2_disp[a];
        s3_pos[a]  <= s2_pos[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: delta = floor(force * step_squared / 2^32)
  // ---------------------------------------------------------------------------
  localparam int SPROD_W = ACC_W + STEP_W + 1;  // 65
  localparam int DELTA_W = SPROD_W - STEP_W;    // 33

  logic signed [STEP_W:0]    step_s;
  logic signed [SPROD_W-1:0] step_prod [2];
  logic signed [DELTA_W-1:0] s4_delta  [2];
  logic signed [POS_W:0]     s4_disp   [2];
  logic signed [POS_W-1:0]   s4_pos    [2];

  assign step_s = $signed({1'b0, step_squared});

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      step_prod[a] = SPROD_W'(s3_force[a]) * SPROD_W'(step_s);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int a = 0; a < 2; a++) begin
        s4_delta[a] <= step_prod[a][SPROD_W-1:STEP_W];
        s4_disp[a]  <= s3_disp[a];
        s4_pos[a]   <= s3_pos[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: p = sat24(pos + disp + delta)
  // ---------------------------------------------------------------------------
  localparam int PSUM_W = DELTA_W + 2;  // 35

  logic signed [PSUM_W-1:0] psum  [2];
  logic signed [POS_W-1:0]  s5_p  [2];
  logic signed [POS_W-1:0]  s5_pos [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      psum[a] = PSUM_W'(s4_pos[a]) + PSUM_W'(s4_disp[a]) + PSUM_W'(s4_delta[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int a = 0; a < 2; a++) begin
        if ((&psum[a][PSUM_W-1:POS_W-1]) || !(|psum[a][PSUM_W-1:POS_W-1])) begin
          s5_p[a] <= psum[a][POS_W-1:0];
        end else begin
          s5_p[a] <= psum[a][PSUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                       : {1'b0, {(POS_W-1){1'b1}}};
        end
        s5_pos[a] <= s4_pos[a];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: wall test and bounce, output register
  // ---------------------------------------------------------------------------
  localparam int NPSUM_W = POS_W + 2;  // 26

  logic [POS_W:0]            mag     [2];
  logic                      hit     [2];
  logic signed [POS_W-1:0]   wall    [2];
  logic signed [POS_W:0]     step_d  [2];  // p - pos, pre-correction step
  logic signed [NPSUM_W-1:0] npsum   [2];
  logic signed [POS_W-1:0]   nprev   [2];
  logic signed [POS_W-1:0]   o_pos   [2];
  logic signed [POS_W-1:0]   o_prev  [2];
  logic                      o_hit   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag[a]    = s5_p[a][POS_W-1] ? -{1'b1, s5_p[a]} : {1'b0, s5_p[a]};
      hit[a]    = mag[a] > {2'b00, wall_bound[a]};
      wall[a]   = s5_p[a][POS_W-1] ? -{1'b0, wall_bound[a]} : {1'b0, wall_bound[a]};
      step_d[a] = {s5_p[a][POS_W-1], s5_p[a]} - {s5_pos[a][POS_W-1], s5_pos[a]};
      // floor((p - pos) / 2) is the top bits of the step
      npsum[a]  = NPSUM_W'(wall[a]) + NPSUM_W'($signed(step_d[a][POS_W:1]));
      if ((&npsum[a][NPSUM_W-1:POS_W-1]) || !(|npsum[a][NPSUM_W-1:POS_W-1])) begin
        nprev[a] = npsum[a][POS_W-1:0];
      end else begin
        nprev[a] = npsum[a][NPSUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                       : {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int a = 0; a < 2; a++) begin
        o_pos[a]  <= hit[a] ? wall[a]  : s5_p[a];
        o_prev[a] <= hit[a] ? nprev[a] : s5_pos[a];
        o_hit[a]  <= hit[a];
      end
    end
  end

  assign result.valid           = vld[NSTG];
  assign result.data.new_pos_x  = o_pos[0];
  assign result.data.new_pos_y  = o_pos[1];
  assign result.data.new_prev_x = o_prev[0];
  assign result.data.new_prev_y = o_prev[1];
  assign result.data.hit_wall_x = o_hit[0];
  assign result.data.hit_wall_y = o_hit[1];

endmodule
